// ===== hw/rtl/symmetric_coo_to_csr_builder_defines.svh =====
// assertion helpers used by the builder back end module
`ifndef SYMMETRIC_COO_TO_CSR_BUILDER_DEFINES_SVH
`define SYMMETRIC_COO_TO_CSR_BUILDER_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define CTCB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// invariant checked on every rising clock edge outside reset
`define CTCB_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

// ===== hw/rtl/ctcb_pkg.sv =====
package ctcb_pkg;

    // default sizing
    localparam int DEF_MAX_ROWS  = 1024;
    localparam int DEF_MAX_EDGES = 4096;

    // fixed field widths
    localparam int OPCODE_W    = 2;
    localparam int INDEX_W     = 11;
    localparam int KIND_W      = 2;
    localparam int VALUE_W     = 14;
    localparam int ROW_COUNT_W = 11;
    localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = 11'd1024;

    // depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // input opcodes
    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    // output word kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_PTR = 2'd0,
        KIND_COL = 2'd1,
        KIND_END = 2'd2
    } kind_t;

    // jobs passed through the queue
    typedef enum logic [1:0] {
        JOB_ADD   = 2'd0,
        JOB_READ  = 2'd1,
        JOB_CLEAR = 2'd2
    } job_kind_t;

    localparam int JOB_KIND_W = 2;

    // back end sequencer states
    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_ADD0,
        S_ADD1,
        S_ADD2,
        S_ADD3,
        S_PTR,
        S_PTR_EMIT,
        S_SCAN,
        S_SCAN_CHK,
        S_COL,
        S_COL_EMIT,
        S_END_EMIT
    } back_state_t;

    // status from back end to front end
    typedef struct packed {
        logic sweeping;
        logic sweep_done;
    } back_status_t;

endpackage

// ===== hw/rtl/ctcb_fifo.sv =====
module ctcb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/ctcb_front.sv =====
module ctcb_front #(
    parameter int MAX_ROWS  = ctcb_pkg::DEF_MAX_ROWS,
    parameter int MAX_EDGES = ctcb_pkg::DEF_MAX_EDGES,
    parameter int MW        = $clog2(MAX_ROWS + 1),
    parameter int JW        = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ctcb_pkg::OPCODE_W-1:0]   opcode,
    input  logic [ctcb_pkg::INDEX_W-1:0]    first_index,
    input  logic [ctcb_pkg::INDEX_W-1:0]    second_index,
    input  logic [MW-1:0]                   eff_rows,
    input  ctcb_pkg::back_status_t          back_status,
    input  logic                            queue_full,
    output logic                            queue_push,
    output logic [JW-1:0]                   queue_data
);
    import ctcb_pkg::*;

    localparam int RW       = $clog2(MAX_ROWS);
    localparam int NODE_CAP = 2 * MAX_EDGES;
    localparam int NW       = $clog2(NODE_CAP);
    localparam int CW       = $clog2(NODE_CAP + 1);

    logic [CW-1:0] nodes_used_reg, nodes_used_next;
    logic          clr_wait_reg, clr_wait_next;
    logic          accept;
    logic          in_range;
    logic          has_room;
    logic [RW-1:0] row_a;
    logic [RW-1:0] row_b;

    assign in_stall = queue_full || back_status.sweeping || clr_wait_reg;
    assign accept   = in_valid && !in_stall;

    // edge checks
    assign in_range = (first_index != '0) && (second_index != '0)
                   && (32'(first_index) <= 32'(eff_rows))
                   && (32'(second_index) <= 32'(eff_rows));
    assign has_room = (32'(nodes_used_reg) + 32'd2) <= 32'(NODE_CAP);
    assign row_a    = RW'(32'(first_index) - 32'd1);
    assign row_b    = RW'(32'(second_index) - 32'd1);

    // classify the item and hand a job to the back end
    always_comb
    begin
        queue_push      = 1'b0;
        queue_data      = {JOB_READ, row_a, row_b, nodes_used_reg[NW-1:0]};
        nodes_used_next = nodes_used_reg;
        clr_wait_next   = clr_wait_reg;
        if (back_status.sweep_done)
        begin
            clr_wait_next = 1'b0;
        end
        if (accept)
        begin
            case (opcode)
                OP_ADD:
                begin
                    if (in_range && has_room)
                    begin
                        queue_push      = 1'b1;
                        queue_data      = {JOB_ADD, row_a, row_b, nodes_used_reg[NW-1:0]};
                        nodes_used_next = nodes_used_reg + CW'(2);
                    end
                end
                OP_READ:
                begin
                    queue_push = 1'b1;
                end
                OP_CLEAR:
                begin
                    queue_push      = 1'b1;
                    queue_data      = {JOB_CLEAR, row_a, row_b, nodes_used_reg[NW-1:0]};
                    nodes_used_next = '0;
                    clr_wait_next   = 1'b1;
                end
                default:
                begin
                    queue_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_used_reg <= '0;
            clr_wait_reg   <= 1'b0;
        end
        else
        begin
            nodes_used_reg <= nodes_used_next;
            clr_wait_reg   <= clr_wait_next;
        end
    end

endmodule

// ===== hw/rtl/ctcb_back.sv =====
`include "symmetric_coo_to_csr_builder_defines.svh"

module ctcb_back #(
    parameter int MAX_ROWS  = ctcb_pkg::DEF_MAX_ROWS,
    parameter int MAX_EDGES = ctcb_pkg::DEF_MAX_EDGES,
    parameter int MW        = $clog2(MAX_ROWS + 1),
    parameter int JW        = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [MW-1:0]                  eff_rows,
    input  logic                           cfg_restart,
    input  logic                           queue_empty,
    input  logic [JW-1:0]                  queue_data,
    output logic                           queue_pop,
    output ctcb_pkg::back_status_t         back_status,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ctcb_pkg::KIND_W-1:0]    word_kind,
    output logic [ctcb_pkg::VALUE_W-1:0]   word_value,
    output logic                           is_last
);
    import ctcb_pkg::*;

    localparam int RW       = $clog2(MAX_ROWS);
    localparam int NODE_CAP = 2 * MAX_EDGES;
    localparam int NW       = $clog2(NODE_CAP);
    localparam int CW       = $clog2(NODE_CAP + 1);
    localparam int KW       = $clog2(MAX_ROWS + NODE_CAP + 2);
    localparam int LE       = 1 + 2 * NW;

    // memories: per-row counts, per-row list descriptors, node pool
    logic [CW-1:0] cnt_mem  [MAX_ROWS];
    logic [LE-1:0] fst_mem  [MAX_ROWS];
    logic [LE-1:0] snd_mem  [MAX_ROWS];
    logic [RW-1:0] col_mem  [NODE_CAP];
    logic [NW-1:0] link_mem [NODE_CAP];

    logic          cnt_we;
    logic [RW-1:0] cnt_waddr, cnt_raddr;
    logic [CW-1:0] cnt_wdata, cnt_rdata_reg;
    logic          fst_we, snd_we;
    logic [RW-1:0] lst_waddr, lst_raddr;
    logic [LE-1:0] lst_wdata, fst_rdata_reg, snd_rdata_reg;
    logic          col_we;
    logic [NW-1:0] col_waddr, node_raddr;
    logic [RW-1:0] col_wdata, col_rdata_reg;
    logic          link_we;
    logic [NW-1:0] link_waddr, link_wdata, link_rdata_reg;

    back_state_t   state_reg, state_next;
    logic [RW-1:0] clr_idx_reg, clr_idx_next;
    logic [RW-1:0] a_reg, a_next;
    logic [RW-1:0] b_reg, b_next;
    logic [NW-1:0] node_reg, node_next;
    logic [KW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] offset_reg, offset_next;
    logic [MW-1:0] walk_row_reg, walk_row_next;
    logic          walk_list_reg, walk_list_next;
    logic          walk_active_reg, walk_active_next;
    logic [NW-1:0] walk_node_reg, walk_node_next;
    logic [NW-1:0] walk_tail_reg, walk_tail_next;
    logic          out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic          last_reg, last_next;

    logic              out_free;
    logic              out_load;
    logic              restart;
    logic [KW-1:0]     m_ext;
    logic [KW-1:0]     emitted;
    logic [JOB_KIND_W-1:0] job_kind;
    logic [LE-1:0]     lst_rdata;

    assign out_valid  = out_valid_reg;
    assign word_kind  = kind_reg;
    assign word_value = value_reg;
    assign is_last    = last_reg;
    assign out_free   = !out_valid_reg || !out_stall;
    assign m_ext      = KW'(eff_rows);
    assign emitted    = cursor_reg - m_ext - KW'(1);
    assign job_kind   = queue_data[JW-1 -: JOB_KIND_W];
    assign lst_rdata  = walk_list_reg ? snd_rdata_reg : fst_rdata_reg;

    // sequencer: sweep, add read-modify-write, readout walk
    always_comb
    begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        node_next        = node_reg;
        cursor_next      = cursor_reg;
        offset_next      = offset_reg;
        walk_row_next    = walk_row_reg;
        walk_list_next   = walk_list_reg;
        walk_active_next = walk_active_reg;
        walk_node_next   = walk_node_reg;
        walk_tail_next   = walk_tail_reg;
        kind_next        = kind_reg;
        value_next       = value_reg;
        last_next        = last_reg;
        out_load         = 1'b0;
        restart          = cfg_restart;
        queue_pop        = 1'b0;
        back_status      = '{sweeping: 1'b0, sweep_done: 1'b0};

        cnt_we     = 1'b0;
        cnt_waddr  = a_reg;
        cnt_wdata  = cnt_rdata_reg + CW'(1);
        cnt_raddr  = a_reg;
        fst_we     = 1'b0;
        snd_we     = 1'b0;
        lst_waddr  = a_reg;
        lst_wdata  = '0;
        lst_raddr  = a_reg;
        col_we     = 1'b0;
        col_waddr  = node_reg;
        col_wdata  = b_reg;
        node_raddr = walk_node_reg;
        link_we    = 1'b0;
        link_waddr = fst_rdata_reg[NW-1:0];
        link_wdata = node_reg;

        case (state_reg)
            S_CLR:
            begin
                back_status.sweeping = 1'b1;
                cnt_we    = 1'b1;
                cnt_waddr = clr_idx_reg;
                cnt_wdata = '0;
                fst_we    = 1'b1;
                snd_we    = 1'b1;
                lst_waddr = clr_idx_reg;
                lst_wdata = '0;
                if (clr_idx_reg == RW'(MAX_ROWS - 1))
                begin
                    back_status.sweep_done = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + RW'(1);
                end
            end
            S_IDLE:
            begin
                if (!queue_empty)
                begin
                    queue_pop = 1'b1;
                    a_next    = queue_data[2*RW+NW-1 -: RW];
                    b_next    = queue_data[RW+NW-1 -: RW];
                    node_next = queue_data[NW-1:0];
                    case (job_kind)
                        JOB_ADD:
                        begin
                            state_next = S_ADD0;
                        end
                        JOB_READ:
                        begin
                            if (cursor_reg <= m_ext)
                            begin
                                state_next = S_PTR;
                            end
                            else if (emitted < KW'(offset_reg))
                            begin
                                state_next = walk_active_reg ? S_COL : S_SCAN;
                            end
                            else
                            begin
                                state_next = S_END_EMIT;
                            end
                        end
                        JOB_CLEAR:
                        begin
                            restart      = 1'b1;
                            clr_idx_next = '0;
                            state_next   = S_CLR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD0:
            begin
                cnt_raddr = a_reg;
                lst_raddr = a_reg;
                col_we    = 1'b1;
                col_waddr = node_reg;
                col_wdata = b_reg;
                state_next = S_ADD1;
            end
            S_ADD1:
            begin
                // append to the first list of row a
                cnt_we    = 1'b1;
                cnt_waddr = a_reg;
                fst_we    = 1'b1;
                lst_waddr = a_reg;
                if (fst_rdata_reg[LE-1])
                begin
                    lst_wdata  = {1'b1, fst_rdata_reg[2*NW-1 -: NW], node_reg};
                    link_we    = 1'b1;
                    link_waddr = fst_rdata_reg[NW-1:0];
                    link_wdata = node_reg;
                end
                else
                begin
                    lst_wdata = {1'b1, node_reg, node_reg};
                end
                state_next = S_ADD2;
            end
            S_ADD2:
            begin
                cnt_raddr = b_reg;
                lst_raddr = b_reg;
                col_we    = 1'b1;
                col_waddr = node_reg + NW'(1);
                col_wdata = a_reg;
                state_next = S_ADD3;
            end
            S_ADD3:
            begin
                // append to the second list of row b
                cnt_we    = 1'b1;
                cnt_waddr = b_reg;
                snd_we    = 1'b1;
                lst_waddr = b_reg;
                if (snd_rdata_reg[LE-1])
                begin
                    lst_wdata  = {1'b1, snd_rdata_reg[2*NW-1 -: NW], node_reg + NW'(1)};
                    link_we    = 1'b1;
                    link_waddr = snd_rdata_reg[NW-1:0];
                    link_wdata = node_reg + NW'(1);
                end
                else
                begin
                    lst_wdata = {1'b1, node_reg + NW'(1), node_reg + NW'(1)};
                end
                restart    = 1'b1;
                state_next = S_IDLE;
            end
            S_PTR:
            begin
                cnt_raddr  = cursor_reg[RW-1:0];
                state_next = S_PTR_EMIT;
            end
            S_PTR_EMIT:
            begin
                // keep the count read steady while the output waits
                cnt_raddr = cursor_reg[RW-1:0];
                if (out_free)
                begin
                    out_load   = 1'b1;
                    kind_next  = KIND_PTR;
                    value_next = VALUE_W'(32'(offset_reg));
                    last_next  = 1'b0;
                    if (cursor_reg < m_ext)
                    begin
                        offset_next = offset_reg + cnt_rdata_reg;
                    end
                    cursor_next = cursor_reg + KW'(1);
                    state_next  = S_IDLE;
                end
            end
            S_SCAN:
            begin
                lst_raddr  = walk_row_reg[RW-1:0];
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                // skip empty lists until one holds nodes
                if (lst_rdata[LE-1])
                begin
                    walk_active_next = 1'b1;
                    walk_node_next   = lst_rdata[2*NW-1 -: NW];
                    walk_tail_next   = lst_rdata[NW-1:0];
                    state_next       = S_COL;
                end
                else
                begin
                    if (walk_list_reg)
                    begin
                        walk_list_next = 1'b0;
                        walk_row_next  = walk_row_reg + MW'(1);
                    end
                    else
                    begin
                        walk_list_next = 1'b1;
                    end
                    state_next = S_SCAN;
                end
            end
            S_COL:
            begin
                node_raddr = walk_node_reg;
                state_next = S_COL_EMIT;
            end
            S_COL_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    kind_next  = KIND_COL;
                    value_next = VALUE_W'(32'(col_rdata_reg));
                    last_next  = (emitted + KW'(1)) == KW'(offset_reg);
                    if (walk_node_reg == walk_tail_reg)
                    begin
                        walk_active_next = 1'b0;
                        if (walk_list_reg)
                        begin
                            walk_list_next = 1'b0;
                            walk_row_next  = walk_row_reg + MW'(1);
                        end
                        else
                        begin
                            walk_list_next = 1'b1;
                        end
                    end
                    else
                    begin
                        walk_node_next = link_rdata_reg;
                    end
                    cursor_next = cursor_reg + KW'(1);
                    state_next  = S_IDLE;
                end
            end
            S_END_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    kind_next  = KIND_END;
                    value_next = '0;
                    last_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // readout restarts at the first row pointer
        if (restart)
        begin
            cursor_next      = '0;
            offset_next      = '0;
            walk_row_next    = '0;
            walk_list_next   = 1'b0;
            walk_active_next = 1'b0;
        end

        out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLR;
            clr_idx_reg     <= '0;
            cursor_reg      <= '0;
            offset_reg      <= '0;
            walk_row_reg    <= '0;
            walk_list_reg   <= 1'b0;
            walk_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_idx_reg     <= clr_idx_next;
            cursor_reg      <= cursor_next;
            offset_reg      <= offset_next;
            walk_row_reg    <= walk_row_next;
            walk_list_reg   <= walk_list_next;
            walk_active_reg <= walk_active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        node_reg      <= node_next;
        walk_node_reg <= walk_node_next;
        walk_tail_reg <= walk_tail_next;
        kind_reg      <= kind_next;
        value_reg     <= value_next;
        last_reg      <= last_next;
    end

    // row count memory
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata_reg <= cnt_mem[cnt_raddr];
    end

    // first list descriptors
    always_ff @(posedge clk)
    begin
        if (fst_we)
        begin
            fst_mem[lst_waddr] <= lst_wdata;
        end
        fst_rdata_reg <= fst_mem[lst_raddr];
    end

    // second list descriptors
    always_ff @(posedge clk)
    begin
        if (snd_we)
        begin
            snd_mem[lst_waddr] <= lst_wdata;
        end
        snd_rdata_reg <= snd_mem[lst_raddr];
    end

    // node columns
    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            col_mem[col_waddr] <= col_wdata;
        end
        col_rdata_reg <= col_mem[node_raddr];
    end

    // node links
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata_reg <= link_mem[node_raddr];
    end

    `CTCB_ASSERT_IMP(a_no_pop_in_sweep, state_reg == S_CLR, !queue_pop, "job taken during sweep")
    `CTCB_ASSERT_IMP(a_load_when_free, out_load, !out_valid_reg || !out_stall, "output overwritten")
    `CTCB_ASSERT_ALWAYS(a_cursor_bound, cursor_reg <= m_ext + KW'(1) + KW'(offset_reg), "cursor past end")

endmodule

// ===== hw/rtl/symmetric_coo_to_csr_builder.sv =====
// Builds the CSR form of a symmetric 0/1 matrix from one-based edge pairs.
// Input channel (in_valid/in_stall): opcode add, read or clear with two
// indices. Output channel (out_valid/out_stall): one word per read item,
// row pointers first, then column indices, then end-of-data words.
// cfg_wr_en/cfg_wr_data set the row count; write it only while idle.
// An item is classified by the front end and queued; the back end does the
// memory work. Add: in the back end, a job pop, then read-modify-writes of
// a row count and a list descriptor for each of the two rows. Read: a row
// pointer or column word takes a pop, a memory read and an emit, plus a
// scan read and check for each empty row list skipped; an end word takes a
// pop and an emit. The result is registered and shows in the cycle after
// the emit. Adds and reads run one at a time through the back end; the
// two-entry queue keeps taking items. After reset and after a clear item,
// a sweep over all MAX_ROWS rows empties the row store; in_stall is high
// during it. When out_stall is high the result holds and the back end
// waits, the queue then fills and in_stall rises.
module symmetric_coo_to_csr_builder #(
    parameter int MAX_ROWS  = ctcb_pkg::DEF_MAX_ROWS,
    parameter int MAX_EDGES = ctcb_pkg::DEF_MAX_EDGES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ctcb_pkg::OPCODE_W-1:0]     opcode,
    input  logic [ctcb_pkg::INDEX_W-1:0]      first_index,
    input  logic [ctcb_pkg::INDEX_W-1:0]      second_index,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ctcb_pkg::KIND_W-1:0]       word_kind,
    output logic [ctcb_pkg::VALUE_W-1:0]      word_value,
    output logic                              is_last,
    input  logic                              cfg_wr_en,
    input  logic [ctcb_pkg::ROW_COUNT_W-1:0]  cfg_wr_data
);
    import ctcb_pkg::*;

    localparam int MW = $clog2(MAX_ROWS + 1);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int NW = $clog2(2 * MAX_EDGES);
    localparam int JW = JOB_KIND_W + 2 * RW + NW;

    logic [ROW_COUNT_W-1:0] row_count_reg;
    logic [MW-1:0]          eff_rows;
    back_status_t           back_status;
    logic                   q_push, q_pop, q_full, q_empty;
    logic [JW-1:0]          q_wdata, q_rdata;

    // row count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            row_count_reg <= cfg_wr_data;
        end
    end

    // row count saturated into one to MAX_ROWS
    always_comb
    begin
        if (row_count_reg == '0)
        begin
            eff_rows = MW'(1);
        end
        else if (32'(row_count_reg) > MAX_ROWS)
        begin
            eff_rows = MW'(MAX_ROWS);
        end
        else
        begin
            eff_rows = MW'(32'(row_count_reg));
        end
    end

    ctcb_front #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_EDGES (MAX_EDGES),
        .MW        (MW),
        .JW        (JW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .first_index  (first_index),
        .second_index (second_index),
        .eff_rows     (eff_rows),
        .back_status  (back_status),
        .queue_full   (q_full),
        .queue_push   (q_push),
        .queue_data   (q_wdata)
    );

    ctcb_fifo #(
        .WIDTH (JW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .full      (q_full),
        .empty     (q_empty)
    );

    ctcb_back #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_EDGES (MAX_EDGES),
        .MW        (MW),
        .JW        (JW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .eff_rows    (eff_rows),
        .cfg_restart (cfg_wr_en),
        .queue_empty (q_empty),
        .queue_data  (q_rdata),
        .queue_pop   (q_pop),
        .back_status (back_status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .word_kind   (word_kind),
        .word_value  (word_value),
        .is_last     (is_last)
    );

endmodule
